// ===== sv/mrt_pkg.sv =====
package mrt_pkg;

	// Table geometry.
	localparam int MAX_REGIONS = 16;
	localparam int PAGE_BITS   = 12;

	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK                = 3'd0,
		ST_FULL              = 3'd1,
		ST_START_MISALIGNED  = 3'd2,
		ST_LENGTH_MISALIGNED = 3'd3,
		ST_OVERLAP           = 3'd4,
		ST_MISS              = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_SCAN,
		ENG_EMIT
	} eng_state_t;

	// One stored region, as held in the table memory.
	typedef struct packed {
		logic [63:0] start;
		logic [63:0] length;
		logic [15:0] attrs;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One result, passed from the engine to the output register.
	typedef struct packed {
		status_t     status;
		logic [3:0]  index;
		logic [63:0] start;
		logic [63:0] length;
		logic [15:0] attrs;
	} res_t;

	// The result carries only the low four bits of a table index.
	function automatic logic [3:0] idx_field(logic [IDX_W-1:0] i);
		logic [IDX_W+3:0] w;
		w = {4'b0000, i};
		return w[3:0];
	endfunction

endpackage

// ===== sv/mrt_if.sv =====
interface mrt_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] address;
	logic [63:0] span;
	logic [3:0]  access_bytes;
	logic [15:0] attributes;

	modport source (
		output valid, command, address, span, access_bytes, attributes,
		input  ready
	);
	modport sink (
		input  valid, command, address, span, access_bytes, attributes,
		output ready
	);
endinterface

interface mrt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  entry_index;
	logic [63:0] entry_start;
	logic [63:0] entry_length;
	logic [15:0] entry_attributes;

	modport source (
		output valid, status, entry_index, entry_start, entry_length, entry_attributes,
		input  ready
	);
	modport sink (
		input  valid, status, entry_index, entry_start, entry_length, entry_attributes,
		output ready
	);
endinterface

// ===== sv/mrt_ram.sv =====
module mrt_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [ADDR_W-1:0]     raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/mrt_engine.sv =====
module mrt_engine import mrt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	mrt_req_if.sink req,
	output res_t   res,
	output logic   res_valid,
	input  logic   res_ready
);
	eng_state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_idx_q;
	logic             cmp_vld_s1;

	cmd_t        cmd_q;
	logic [63:0] addr_q;
	logic [63:0] span_q;
	logic [15:0] attr_q;
	logic [64:0] end_q;
	res_t        res_q, res_d;
	logic        res_ld;

	logic        issue;
	logic        we;
	entry_t      wentry, rentry;
	logic [ENTRY_W-1:0] rdata;

	logic        accept;
	logic [3:0]  acc_width;
	logic [64:0] end_in;
	logic        start_bad, len_bad, full;

	logic [64:0] r_end;
	logic        overlap, contains, hit;

	mrt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wentry),
		.re    (issue),
		.raddr (issue_idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign wentry = '{start: addr_q, length: span_q, attrs: attr_q};
	assign rentry = entry_t'(rdata);

	// Access width is clamped to one to eight bytes.
	always_comb begin
		if (req.access_bytes == 4'd0) begin
			acc_width = 4'd1;
		end else if (req.access_bytes > 4'd8) begin
			acc_width = 4'd8;
		end else begin
			acc_width = req.access_bytes;
		end
	end

	assign end_in = (req.command == CMD_INSERT)
		? ({1'b0, req.address} + {1'b0, req.span})
		: ({1'b0, req.address} + {61'd0, acc_width});

	assign start_bad = req.address[PAGE_BITS-1:0] != '0;
	assign len_bad   = req.span[PAGE_BITS-1:0] != '0;
	assign full      = count_q == CNT_W'(MAX_REGIONS);

	// Compare against the entry read in the previous cycle.
	assign r_end    = {1'b0, rentry.start} + {1'b0, rentry.length};
	assign overlap  = ({1'b0, addr_q} < r_end) && ({1'b0, rentry.start} < end_q);
	assign contains = (addr_q >= rentry.start) && !(r_end < end_q);
	assign hit      = (cmd_q == CMD_INSERT) ? overlap : contains;

	assign accept = req.valid && req.ready;

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		issue     = 1'b0;
		we        = 1'b0;
		res_valid = 1'b0;
		res_ld    = 1'b0;
		res_d     = '{status: ST_OK, index: '0, start: '0, length: '0, attrs: '0};
		unique case (state_q)
			ENG_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.command == CMD_INSERT && (full || start_bad || len_bad)) begin
						res_ld = 1'b1;
						if (full) begin
							res_d.status = ST_FULL;
						end else if (start_bad) begin
							res_d.status = ST_START_MISALIGNED;
						end else begin
							res_d.status = ST_LENGTH_MISALIGNED;
						end
						state_d = ENG_EMIT;
					end else begin
						state_d = ENG_SCAN;
					end
				end
			end
			ENG_SCAN: begin
				issue = issue_idx_q < count_q;
				if (cmp_vld_s1 && hit) begin
					res_ld = 1'b1;
					if (cmd_q == CMD_INSERT) begin
						res_d.status = ST_OVERLAP;
					end else begin
						res_d = '{status: ST_OK,
							index:  idx_field(issue_idx_q[IDX_W-1:0] - IDX_W'(1)),
							start:  rentry.start,
							length: rentry.length,
							attrs:  rentry.attrs};
					end
					state_d = ENG_EMIT;
				end else if (!issue && !cmp_vld_s1) begin
					res_ld = 1'b1;
					if (cmd_q == CMD_INSERT) begin
						we    = 1'b1;
						res_d = '{status: ST_OK, index: idx_field(count_q[IDX_W-1:0]),
							start: addr_q, length: span_q, attrs: attr_q};
					end else begin
						res_d.status = ST_MISS;
					end
					state_d = ENG_EMIT;
				end
			end
			ENG_EMIT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ENG_IDLE;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ENG_IDLE;
			count_q     <= '0;
			issue_idx_q <= '0;
			cmp_vld_s1  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue && (state_d == ENG_SCAN);
			if (accept) begin
				issue_idx_q <= '0;
			end else if (issue) begin
				issue_idx_q <= issue_idx_q + CNT_W'(1);
			end
			if (we) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(req.command);
			addr_q <= req.address;
			span_q <= req.span;
			attr_q <= req.attributes;
			end_q  <= end_in;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;
endmodule

// ===== sv/memory_region_table_unit.sv =====
// Channel  Modport  Transfer carries
// -------  -------  ----------------------------------------------------------
// req      sink     command, address, span, access_bytes, attributes
// rsp      source   status, entry_index, entry_start, entry_length, entry_attributes
//
// The table memory has one read port and gives one entry per cycle. A lookup hit or an
// insert overlap ends the scan at the matching entry; a lookup miss or an accepted insert
// reads every stored entry, and a refused insert caught by the up-front checks reads none.
// The engine takes the next request only after the result of the current one has moved
// into the output register. Reset clears the region count; the table contents stay
// unwritten and are never read beyond the count. A stalled rsp holds its result in the
// output register while the engine takes and works on the next request.
module memory_region_table_unit import mrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	mrt_req_if.sink  req,
	mrt_rsp_if.source rsp
);
	// The engine owns the table memory and the region count. It serves one request at
	// a time, so an insert always writes its entry before the next request's first
	// read is issued, and no forwarding path is needed.
	res_t res;
	logic res_valid;
	logic res_ready;

	res_t out_q;
	logic out_vld_q;

	mrt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	// Output register: a result moves in when the register is empty or its current
	// content is being transferred in the same cycle.
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid            = out_vld_q;
	assign rsp.status           = 3'(out_q.status);
	assign rsp.entry_index      = out_q.index;
	assign rsp.entry_start      = out_q.start;
	assign rsp.entry_length     = out_q.length;
	assign rsp.entry_attributes = out_q.attrs;
endmodule

// ===== test/tb_memory_region_table_unit.sv =====
module tb_memory_region_table_unit;
	import mrt_pkg::*;

	// The low address bits that must be zero for a page aligned start or length.
	localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_BITS) - 64'd1;

	// Length of the long stretch during which the response side refuses every transfer.
	localparam int unsigned HOLD_CYCLES = 300;

	// One request as the sender offers it on the req channel.
	typedef struct {
		cmd_t        command;
		logic [63:0] address;
		logic [63:0] span;
		logic [3:0]  access_bytes;
		logic [15:0] attributes;
	} region_req_t;

	logic clk;
	logic arst_n;

	mrt_req_if req_ch ();
	mrt_rsp_if rsp_ch ();

	memory_region_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Our own copy of the region table. Entries at or above held_count are never read,
	// which mirrors the block: its memory is left unwritten after reset.
	logic [63:0] held_start  [MAX_REGIONS];
	logic [63:0] held_length [MAX_REGIONS];
	logic [15:0] held_attrs  [MAX_REGIONS];
	int          held_count;

	// Results worked out at request transfer time, oldest first.
	res_t pending_results [$];

	int          mismatch_count;
	int unsigned send_idle_pct;
	int unsigned rsp_idle_pct;
	// Bumped by a test to ask the response side for one long hold-off.
	int unsigned hold_requests;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Applies one request to the table copy and returns the result the block should give.
	// Inserts are refused in a fixed order of priority: full, start, length, overlap.
	// All end-of-range sums are formed in 65 bits, so a region may reach past 2^64.
	function automatic res_t table_outcome(region_req_t r);
		res_t        o;
		logic [64:0] new_end;
		logic [64:0] acc_end;
		logic [64:0] reg_end;
		logic [3:0]  width;
		bit          hit;
		o = '0;
		hit = 1'b0;
		if (r.command == CMD_INSERT) begin
			if (held_count >= MAX_REGIONS) begin
				o.status = ST_FULL;
			end else if ((r.address & PAGE_MASK) != 64'd0) begin
				o.status = ST_START_MISALIGNED;
			end else if ((r.span & PAGE_MASK) != 64'd0) begin
				o.status = ST_LENGTH_MISALIGNED;
			end else begin
				new_end = {1'b0, r.address} + {1'b0, r.span};
				for (int i = 0; i < held_count; i++) begin
					reg_end = {1'b0, held_start[i]} + {1'b0, held_length[i]};
					if ({1'b0, r.address} < reg_end && {1'b0, held_start[i]} < new_end)
						hit = 1'b1;
				end
				if (hit) begin
					o.status = ST_OVERLAP;
				end else begin
					held_start[held_count]  = r.address;
					held_length[held_count] = r.span;
					held_attrs[held_count]  = r.attributes;
					o.status = ST_OK;
					o.index  = 4'(held_count);
					o.start  = r.address;
					o.length = r.span;
					o.attrs  = r.attributes;
					held_count++;
				end
			end
		end else begin
			// A width of zero counts as one byte, anything above eight as eight.
			if (r.access_bytes == 4'd0)
				width = 4'd1;
			else if (r.access_bytes > 4'd8)
				width = 4'd8;
			else
				width = r.access_bytes;
			acc_end = {1'b0, r.address} + 65'(width);
			o.status = ST_MISS;
			for (int i = 0; i < held_count; i++) begin
				reg_end = {1'b0, held_start[i]} + {1'b0, held_length[i]};
				if (!hit && r.address >= held_start[i] && reg_end >= acc_end) begin
					hit = 1'b1;
					o.status = ST_OK;
					o.index  = 4'(i);
					o.start  = held_start[i];
					o.length = held_length[i];
					o.attrs  = held_attrs[i];
				end
			end
		end
		return o;
	endfunction

	function automatic region_req_t region_op(cmd_t c, logic [63:0] a, logic [63:0] s,
			logic [3:0] w, logic [15:0] at);
		region_req_t r;
		r.command      = c;
		r.address      = a;
		r.span         = s;
		r.access_bytes = w;
		r.attributes   = at;
		return r;
	endfunction

	// A lookup that mostly lands inside a stored region or around its edges, so that both
	// hits and near misses are common; the rest are fully random addresses.
	function automatic region_req_t make_lookup();
		region_req_t r;
		int          k;
		logic [63:0] base;
		logic [63:0] len;
		r = region_op(CMD_LOOKUP, {$urandom, $urandom}, {$urandom, $urandom},
			4'($urandom_range(0, 15)), 16'($urandom));
		if (held_count != 0 && $urandom_range(0, 99) < 85) begin
			k    = $urandom_range(0, held_count - 1);
			base = held_start[k];
			len  = held_length[k];
			case ($urandom_range(0, 2))
				0: begin
					r.address = base - 64'd8 + 64'($urandom_range(0, 16));
				end
				1: begin
					r.address = base + len - 64'd12 + 64'($urandom_range(0, 16));
				end
				default: begin
					r.address = base + ((len == 64'd0) ? 64'd0 : ({$urandom, $urandom} % len));
				end
			endcase
		end
		return r;
	endfunction

	// An insert drawn from a mix of fresh well-formed regions, regions aimed at a stored
	// one (inside it or straddling its start), and malformed or degenerate requests.
	function automatic region_req_t make_insert();
		region_req_t r;
		int          k;
		logic [63:0] pages;
		logic [63:0] n;
		r = region_op(CMD_INSERT, {$urandom, $urandom} & ~PAGE_MASK,
			64'($urandom_range(1, 64)) << PAGE_BITS, 4'($urandom_range(0, 15)),
			16'($urandom));
		case ($urandom_range(0, 9))
			0: begin
				r.address = r.address | 64'($urandom_range(1, (1 << PAGE_BITS) - 1));
			end
			1: begin
				r.span = r.span | 64'($urandom_range(1, (1 << PAGE_BITS) - 1));
			end
			2: begin
				r.span = 64'd0;
			end
			3: begin
				r.span = {$urandom, $urandom} & ~PAGE_MASK;
			end
			4, 5, 6, 7: begin
				if (held_count != 0) begin
					k = $urandom_range(0, held_count - 1);
					pages = held_length[k] >> PAGE_BITS;
					if ($urandom_range(0, 1) == 1) begin
						r.address = held_start[k] + (((pages == 64'd0) ? 64'd0 :
							({$urandom, $urandom} % pages)) << PAGE_BITS);
						r.span = 64'($urandom_range(0, 4)) << PAGE_BITS;
					end else begin
						n = 64'($urandom_range(1, 4)) << PAGE_BITS;
						r.address = held_start[k] - n;
						r.span = n + (64'($urandom_range(0, 2)) << PAGE_BITS);
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Offers one request and returns at the falling edge after its transfer. Valid is left
	// high so that back-to-back requests keep it up; an idle gap lowers it first.
	task automatic send_request(input region_req_t r);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= r.command;
		req_ch.address      <= r.address;
		req_ch.span         <= r.span;
		req_ch.access_bytes <= r.access_bytes;
		req_ch.attributes   <= r.attributes;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_results.insert(pending_results.size(), table_outcome(r));
		@(negedge clk);
	endtask

	// Lowers valid and waits until every expected result has come back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// Errors on the empty table and the ordering of refusal reasons come first, then a
	// handful of regions are placed so that the edges, the zero-length rules and the
	// region running past the top of the address space can be probed by lookups.
	task automatic check_directed_cases();
		// Nothing stored yet, so any lookup misses.
		send_request(region_op(CMD_LOOKUP, 64'h0, 64'h0, 4'd1, 16'h0));
		send_request(region_op(CMD_INSERT, 64'h1001, 64'h1000, 4'd0, 16'h1234));
		send_request(region_op(CMD_INSERT, 64'h1000, 64'h1001, 4'd0, 16'h1234));
		// Both start and length are off the page grid; the start is reported.
		send_request(region_op(CMD_INSERT, 64'h10, 64'h10, 4'd0, 16'h1234));
		send_request(region_op(CMD_INSERT, 64'h1000_0000, 64'h4000, 4'd15, 16'hFFFF));
		// Wholly inside, then straddling the start of, the region just stored.
		send_request(region_op(CMD_INSERT, 64'h1000_2000, 64'h1000, 4'd0, 16'h0001));
		send_request(region_op(CMD_INSERT, 64'h0FFF_F000, 64'h2000, 4'd0, 16'h0002));
		// Abutting the end is not an overlap.
		send_request(region_op(CMD_INSERT, 64'h1000_4000, 64'h1000, 4'd0, 16'h0000));
		// A zero-length region overlaps only when it starts strictly inside another.
		send_request(region_op(CMD_INSERT, 64'h1000_1000, 64'h0, 4'd0, 16'h0003));
		send_request(region_op(CMD_INSERT, 64'h1000_0000, 64'h0, 4'd0, 16'h0004));
		// This one ends above 2^64 and must be kept with its 65-bit end.
		send_request(region_op(CMD_INSERT, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 4'd0, 16'hA5A5));
		send_request(region_op(CMD_INSERT, 64'hFFFF_FFFF_FFFF_E000, 64'h2000, 4'd0, 16'h5A5A));
		send_request(region_op(CMD_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_F000, 4'd0, 16'h0005));
		// Width zero counts as one byte.
		send_request(region_op(CMD_LOOKUP, 64'h1000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
			16'hFFFF));
		send_request(region_op(CMD_LOOKUP, 64'h1000_3FF8, 64'h0, 4'd8, 16'h0));
		send_request(region_op(CMD_LOOKUP, 64'h1000_3FF9, 64'h0, 4'd8, 16'h0));
		// Width fifteen counts as eight bytes, so this access spills past the region.
		send_request(region_op(CMD_LOOKUP, 64'h1000_3FFF, 64'h0, 4'd15, 16'h0));
		send_request(region_op(CMD_LOOKUP, 64'h1000_3FFF, 64'h0, 4'd1, 16'h0));
		send_request(region_op(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFF8, 64'h0, 4'd8, 16'h0));
		send_request(region_op(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 4'd9, 16'h0));
		send_request(region_op(CMD_LOOKUP, 64'h0FFF_FFFF, 64'h0, 4'd2, 16'h0));
		send_request(region_op(CMD_LOOKUP, 64'h1000_4FFF, 64'h0, 4'd1, 16'h0));
		drain_results();
	endtask

	// Random traffic, weighted towards inserts, until the table is full or the guard runs out. Many inserts are
	// aimed at stored regions so that the overlap scan is exercised at every depth.
	task automatic check_random_fill();
		int guard;
		guard = 0;
		while (held_count < MAX_REGIONS && guard < 400) begin
			if ($urandom_range(0, 99) < 35)
				send_request(make_lookup());
			else
				send_request(make_insert());
			guard++;
		end
		drain_results();
	endtask

	// With the table full, every insert is refused as full, even a malformed one.
	task automatic check_full_table();
		send_request(region_op(CMD_INSERT, 64'h2000_0000, 64'h1000, 4'd0, 16'h00FF));
		send_request(region_op(CMD_INSERT, 64'h2000_0001, 64'h1000, 4'd0, 16'h00FF));
		send_request(region_op(CMD_INSERT, 64'h2000_0000, 64'h0FFF, 4'd0, 16'h00FF));
		send_request(region_op(CMD_INSERT, held_start[0], held_length[0], 4'd0, 16'h00FF));
		send_request(region_op(CMD_INSERT, 64'h3000_0000, 64'h0, 4'd0, 16'h00FF));
		for (int i = 0; i < 8; i++)
			send_request(make_insert());
		drain_results();
	endtask

	// The response side holds off for a long stretch while requests keep coming without a
	// gap, so the output register and the engine both fill and req must stall.
	task automatic check_output_stall();
		send_idle_pct = 0;
		hold_requests++;
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 99) < 80)
				send_request(make_lookup());
			else
				send_request(make_insert());
		end
		drain_results();
		send_idle_pct = 20;
	endtask

	// The bulk of the run: mostly lookups against the full table, with a stretch in the
	// middle where neither side idles so that transfers run back to back.
	task automatic check_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 3) begin
				send_idle_pct = 0;
				rsp_idle_pct  = 0;
			end
			if (i == count / 3 + 120) begin
				send_idle_pct = 20;
				rsp_idle_pct  = 20;
			end
			if ($urandom_range(0, 99) < 85)
				send_request(make_lookup());
			else
				send_request(make_insert());
		end
		drain_results();
	endtask

	// Response side: ready changes at the falling edge. A hold-off request from a test is
	// noticed here and counted down in this process alone.
	initial begin : rsp_sink
		int unsigned stall_left;
		int unsigned seen_holds;
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		seen_holds = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != seen_holds) begin
				seen_holds = hold_requests;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
			end
		end
	end

	// Every response transfer is matched against the oldest outstanding expectation.
	initial begin : rsp_checker
		res_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: response with nothing expected, expected none, actual %h",
						$time, rsp_ch.status);
				end else begin
					want = pending_results.pop_front();
					compare_field("status", 64'(want.status), 64'(rsp_ch.status));
					compare_field("entry_index", 64'(want.index), 64'(rsp_ch.entry_index));
					compare_field("entry_start", want.start, rsp_ch.entry_start);
					compare_field("entry_length", want.length, rsp_ch.entry_length);
					compare_field("entry_attributes", 64'(want.attrs),
						64'(rsp_ch.entry_attributes));
				end
			end
		end
	end

	initial begin
		#1000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_INSERT;
		req_ch.address      = 64'd0;
		req_ch.span         = 64'd0;
		req_ch.access_bytes = 4'd0;
		req_ch.attributes   = 16'd0;
		held_count     = 0;
		mismatch_count = 0;
		send_idle_pct  = 20;
		rsp_idle_pct   = 20;
		hold_requests  = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_directed_cases();
		check_random_fill();
		check_full_table();
		check_output_stall();
		check_random_traffic(480);

		// A full scan of the table is the longest the block can take over one request.
		repeat (4 * MAX_REGIONS) @(negedge clk);
		if (pending_results.size() != 0) begin
			mismatch_count++;
			$display("%0t: results still outstanding, expected 0, actual %0d", $time,
				pending_results.size());
		end
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/mrt_pkg.sv
sv/mrt_if.sv
sv/mrt_ram.sv
sv/mrt_engine.sv
sv/memory_region_table_unit.sv
test/tb_memory_region_table_unit.sv
